/* rtl/lbm_pkg.sv */
// lbm_pkg: shared types and constants of the label boundary marker.
// Used by lbm_raster, lbm_judge and label_boundary_marker_unit; depends on nothing.
package lbm_pkg;

  localparam int FW_BITS     = 11;  // frame_width register
  localparam int FH_BITS     = 16;  // frame_height register
  localparam int ROW_BITS    = FH_BITS + 1;  // raster row, runs one past the flush row
  localparam int LABEL_IN_W  = 16;
  localparam int OUT_ROW_W   = 16;
  localparam int OUT_COL_W   = 10;
  localparam int TDATA_OUT_W = 32;
  localparam int OUT_PAD_W   = TDATA_OUT_W - OUT_ROW_W - OUT_COL_W - 1;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int NBR_COUNT   = 8;
  localparam int CNT_W       = 4;
  localparam int MIN_DIFF    = 2;   // unmarked differing neighbours needed for a mark

  localparam logic [FW_BITS-1:0] FW_RESET = 11'd640;
  localparam logic [FH_BITS-1:0] FH_RESET = 16'd480;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // which neighbours of the centre pixel lie inside the frame
  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
  } nbr_ok_t;

  // per-item control from the raster scan
  typedef struct packed {
    logic    in_frame;  // item position holds a pixel of the frame
    logic    decide;    // item completes the window of an earlier pixel
    logic    last;      // that pixel is the last one of the frame
    nbr_ok_t ok;
    logic    w_one;     // frame is one column wide
  } scan_ctl_t;

endpackage

/* rtl/lbm_ram.sv */
// lbm_ram: generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module lbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/lbm_raster.sv */
// lbm_raster: raster position of the next item and the per-item window control.
// Depends on lbm_pkg.
module lbm_raster import lbm_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int WW = $clog2(MAX_WIDTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 step,
  input  logic [FW_BITS-1:0]   frame_width,
  input  logic [FH_BITS-1:0]   frame_height,
  output logic [CW-1:0]        col,
  output logic [CW-1:0]        dc,
  output logic [OUT_ROW_W-1:0] dr,
  output scan_ctl_t            ctl
);

  logic [WW-1:0]       eff_w;
  logic [WW-1:0]       w_m1;
  logic [ROW_BITS-1:0] eff_h;
  logic [ROW_BITS-1:0] row;
  logic [ROW_BITS-1:0] row_next;
  logic [ROW_BITS-1:0] dr_full;
  logic [CW-1:0]       col_next;
  logic                at_row_end;

  always_comb begin
    if (frame_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width);
    end
    w_m1  = eff_w - WW'(1);
    eff_h = (frame_height == '0) ? ROW_BITS'(1) : ROW_BITS'(frame_height);
  end

  // centre pixel sits one row and one column behind the item
  always_comb begin
    at_row_end   = (WW'(col) == w_m1);
    ctl.in_frame = (row < eff_h);
    ctl.decide   = (row >= ROW_BITS'(2)) || ((row == ROW_BITS'(1)) && (col != '0));
    ctl.last     = ctl.decide && (row == eff_h + ROW_BITS'(1));
    dc           = (col == '0) ? CW'(w_m1) : col - CW'(1);
    dr_full      = (col == '0) ? row - ROW_BITS'(2) : row - ROW_BITS'(1);
    dr           = OUT_ROW_W'(dr_full);
    ctl.ok.top   = (dr_full != '0);
    ctl.ok.bot   = ((dr_full + ROW_BITS'(1)) < eff_h);
    ctl.ok.left  = (dc != '0);
    ctl.ok.right = (WW'(dc) != w_m1);
    ctl.w_one    = (eff_w == WW'(1));
  end

  always_comb begin
    if (ctl.last) begin
      col_next = '0;
      row_next = '0;
    end else if (at_row_end) begin
      col_next = '0;
      row_next = row + ROW_BITS'(1);
    end else begin
      col_next = col + CW'(1);
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      col <= '0;
      row <= '0;
    end else if (step) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

/* rtl/lbm_judge.sv */
// lbm_judge: 3x3 label window, mark history and the boundary decision.
// Depends on lbm_pkg.
module lbm_judge import lbm_pkg::*; #(
  parameter int LABEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  shift,
  input  logic                  decide,
  input  logic [LABEL_BITS-1:0] new_top,
  input  logic [LABEL_BITS-1:0] new_mid,
  input  logic [LABEL_BITS-1:0] new_bot,
  input  nbr_ok_t               ok,
  input  logic                  ur_mark,
  input  logic                  w_one,
  output logic                  mark
);

  // left and middle columns; the right column is the one arriving now
  logic [LABEL_BITS-1:0] l_top, l_mid, l_bot;
  logic [LABEL_BITS-1:0] m_top, m_mid, m_bot;
  logic                  up_mark;
  logic                  upleft_mark;
  logic                  left_mark;
  logic [NBR_COUNT-1:0]  fresh;
  logic [CNT_W-1:0]      count;

  always_comb begin
    fresh[0] = ok.top && ok.left && (l_top != m_mid) && !upleft_mark;
    fresh[1] = ok.top && (m_top != m_mid) && !up_mark;
    fresh[2] = ok.top && ok.right && (new_top != m_mid) && !ur_mark;
    fresh[3] = ok.left && (l_mid != m_mid) && !left_mark;
    fresh[4] = ok.right && (new_mid != m_mid);
    fresh[5] = ok.bot && ok.left && (l_bot != m_mid);
    fresh[6] = ok.bot && (m_bot != m_mid);
    fresh[7] = ok.bot && ok.right && (new_bot != m_mid);
  end

  always_comb begin
    count = '0;
    for (int i = 0; i < NBR_COUNT; i++) begin
      count = count + CNT_W'(fresh[i]);
    end
    mark = (count >= CNT_W'(MIN_DIFF));
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      l_top <= m_top;
      l_mid <= m_mid;
      l_bot <= m_bot;
      m_top <= new_top;
      m_mid <= new_mid;
      m_bot <= new_bot;
    end
  end

  // up mark of the next centre is this up-right read, or this very mark
  // when the next centre sits directly below
  always_ff @(posedge clk) begin
    if (rst) begin
      up_mark     <= 1'b0;
      upleft_mark <= 1'b0;
      left_mark   <= 1'b0;
    end else if (decide) begin
      left_mark   <= mark;
      upleft_mark <= up_mark;
      up_mark     <= w_one ? mark : ur_mark;
    end
  end

endmodule

/* rtl/label_boundary_marker_unit.sv */
// label_boundary_marker_unit: boundary marking of a label map, 8 neighbours.
// Throughput: one item per cycle when the output does not stall; limit: left-mark recurrence.
// Decision path: a pixel's decision is caused by the item frame_width+1 places later and
//   reaches m_* through the stage B register and then the result register.
// Reset: synchronous rst restores 640x480 and row 0/col 0; label store has no clearing
//   pass, and the mark store needs none since marks are read only after this frame wrote them.
module label_boundary_marker_unit import lbm_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int LABEL_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [LABEL_IN_W-1:0]  s_tdata,   // [15:0] label
  input  logic                   s_tuser,   // [0] flush
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata,   // [15:0] pixel_row, [25:16] pixel_col,
                                            // [26] is_boundary, [31:27] zero
  output logic                   m_tlast,   // frame_done
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int LW2 = 2 * LABEL_BITS;

  // ---------------------------------------------------------------- config
  logic [FW_BITS-1:0] frame_width;
  logic [FH_BITS-1:0] frame_height;
  logic               cfg_we;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_RESET;
      frame_height <= FH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[FW_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[FH_BITS-1:0];
      endcase
    end
  end

  // --------------------------------------------------------- stage A: scan
  // Input side. A flush inside the frame is taken and dropped; every other
  // transaction advances the raster position and enters stage B.
  logic [CW-1:0]        in_col;
  logic [CW-1:0]        scan_dc;
  logic [OUT_ROW_W-1:0] scan_dr;
  scan_ctl_t            scan_ctl;
  logic                 accept;
  logic                 a_fire;
  logic                 b_fire;

  assign accept = s_tvalid && s_tready;
  assign a_fire = accept && !(scan_ctl.in_frame && s_tuser);

  lbm_raster #(.MAX_WIDTH(MAX_WIDTH)) u_raster (
    .clk          (clk),
    .rst          (rst),
    .clear        (cfg_we),
    .step         (a_fire),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .col          (in_col),
    .dc           (scan_dc),
    .dr           (scan_dr),
    .ctl          (scan_ctl)
  );

  // ------------------------------------------------------- stage B register
  // Holds the item while both line stores return their column entry.
  logic                  b_valid;
  scan_ctl_t             b_ctl;
  logic [CW-1:0]         b_col;
  logic [CW-1:0]         b_dc;
  logic [OUT_ROW_W-1:0]  b_row;
  logic [LABEL_BITS-1:0] b_label;
  logic                  lb_byp;
  logic [LW2-1:0]        lb_byp_data;
  logic                  mk_byp;
  logic                  mk_byp_data;

  // stage B only waits when it owes a result, the result register is full and m_tready is low
  assign b_fire   = b_valid && (!b_ctl.decide || !m_tvalid || m_tready);
  assign s_tready = !b_valid || b_fire;

  // ------------------------------------------------------------ line stores
  // Label store: one entry per column, {label two rows up, label one row up}.
  // Mark store: one mark per column, current row at and left of the centre, row
  // above right of it. Both are read at the item's column; a write in the same cycle
  // to that column is forwarded through the bypass registers.
  logic [LW2-1:0]        lb_rdata;
  logic [LW2-1:0]        lb_entry;
  logic [LW2-1:0]        lb_wdata;
  logic [LABEL_BITS-1:0] col_top;
  logic [LABEL_BITS-1:0] col_mid;
  logic                  mk_rdata;
  logic                  ur_mark;
  logic                  mark;
  logic                  mk_we;

  assign lb_entry = lb_byp ? lb_byp_data : lb_rdata;
  assign col_top  = lb_entry[LW2-1:LABEL_BITS];
  assign col_mid  = lb_entry[LABEL_BITS-1:0];
  assign lb_wdata = {col_mid, b_label};
  assign ur_mark  = mk_byp ? mk_byp_data : mk_rdata;
  assign mk_we    = b_fire && b_ctl.decide;

  lbm_ram #(.WIDTH(LW2), .DEPTH(MAX_WIDTH)) u_label_store (
    .clk   (clk),
    .we    (b_fire),
    .waddr (b_col),
    .wdata (lb_wdata),
    .re    (a_fire),
    .raddr (in_col),
    .rdata (lb_rdata)
  );

  lbm_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_mark_store (
    .clk   (clk),
    .we    (mk_we),
    .waddr (b_dc),
    .wdata (mark),
    .re    (a_fire),
    .raddr (in_col),
    .rdata (mk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_fire) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      b_ctl       <= scan_ctl;
      b_col       <= in_col;
      b_dc        <= scan_dc;
      b_row       <= scan_dr;
      b_label     <= LABEL_BITS'(s_tdata);
      lb_byp      <= b_fire && (b_col == in_col);
      lb_byp_data <= lb_wdata;
      mk_byp      <= mk_we && (b_dc == in_col);
      mk_byp_data <= mark;
    end
  end

  // --------------------------------------------------------------- decision
  lbm_judge #(.LABEL_BITS(LABEL_BITS)) u_judge (
    .clk     (clk),
    .rst     (rst),
    .shift   (b_fire),
    .decide  (mk_we),
    .new_top (col_top),
    .new_mid (col_mid),
    .new_bot (b_label),
    .ok      (b_ctl.ok),
    .ur_mark (ur_mark),
    .w_one   (b_ctl.w_one),
    .mark    (mark)
  );

  // --------------------------------------------------------- result register
  logic [OUT_ROW_W-1:0] out_row;
  logic [OUT_COL_W-1:0] out_col;
  logic                 out_bnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (mk_we) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mk_we) begin
      out_row <= b_row;
      out_col <= OUT_COL_W'(b_dc);
      out_bnd <= mark;
      m_tlast <= b_ctl.last;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_bnd, out_col, out_row};

  // ------------------------------------------------------------- assertions
  a_decision_lands: assert property (@(posedge clk) disable iff (rst)
    mk_we |=> m_tvalid)
    else $error("decision did not reach the result register");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (a_fire && scan_ctl.last) |=> !scan_ctl.decide)
    else $error("raster position not back at frame start after last pixel");

  a_flush_dropped: assert property (@(posedge clk) disable iff (rst)
    (accept && scan_ctl.in_frame && s_tuser) |=> !b_valid)
    else $error("flush inside the frame entered the pipeline");

endmodule
